>>> design/key_binding_combo_resolver_top_macros.svh
// ----------------------------------------------------------------------------
// key binding combo resolver assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef KEY_BINDING_COMBO_RESOLVER_TOP_MACROS_SVH
`define KEY_BINDING_COMBO_RESOLVER_TOP_MACROS_SVH

`ifndef SYNTH

// checked on every clock edge outside reset
`define KBCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kbcr assertion failed");

// checked on every clock edge, reset included
`define KBCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("kbcr assertion failed");

`else

`define KBCR_ASSERT(lbl, clk, rst_n, prop)
`define KBCR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/kbcr_pkg.sv
// ----------------------------------------------------------------------------
// kbcr_pkg
// shared types and constants of the key binding combo resolver
// ----------------------------------------------------------------------------
package kbcr_pkg;

  localparam int NUM_KEYS = 32;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W    = $clog2(NUM_KEYS + 1);

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_PREPARE = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  localparam logic [1:0] CFG_USABLE_KEY_MASK = 2'd0;
  localparam logic [1:0] CFG_MENU_KEY_MASK   = 2'd1;
  localparam logic [1:0] CFG_SOUND_ENABLED   = 2'd2;

  localparam int          PLAYER_BIT     = 16;
  localparam logic [31:0] COMBO_ELIGIBLE = 32'hFFFC_FFFF;

  localparam logic [15:0] EV_VOLUME_ANY = 16'h6000;
  localparam logic [15:0] EV_VOLUME_UP  = 16'h2000;
  localparam logic [15:0] EV_SLOT_ANY   = 16'h0300;
  localparam logic [15:0] EV_SLOT_DOWN  = 16'h0200;

  localparam logic [6:0] VOLUME_RESET = 7'd50;
  localparam logic [6:0] VOLUME_MAX   = 7'd100;
  localparam logic [3:0] SLOT_LAST    = 4'd9;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  key_index;
    logic [31:0] binding_word;
    logic [31:0] pad_keys;
  } req_t;

  typedef struct packed {
    logic [15:0] pad_player_one;
    logic [15:0] pad_player_two;
    logic [15:0] new_events;
    logic        menu_request;
    logic [6:0]  volume_level;
    logic [3:0]  save_slot;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_RD,
    ST_P1_ACC,
    ST_P2_RD,
    ST_P2_ACC,
    ST_S_SEL,
    ST_S_KEY,
    ST_S_SRCH,
    ST_S_CHK,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

>>> design/key_binding_combo_resolver_top.sv
// ----------------------------------------------------------------------------
// key_binding_combo_resolver_top
// binding table, combo preparation and pad sample scan on one read port
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------
//   request  | in        | in_valid_i / in_stall_o | in_req_i   (req_t)
//   result   | out       | out_valid_o/ out_stall_i| out_rsp_o  (rsp_t)
//   config   | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// write stores one entry if its index is in range; prepare reads and updates every
// entry in two passes; sample visits every key and reads each pressed one; a combo
// search scans the keys above it for a pressed partner
// input stalled until done; the next request may start while a result waits
// reset: table reads as zero, volume 50, slot 0, no result pending
// ----------------------------------------------------------------------------
`include "key_binding_combo_resolver_top_macros.svh"

module key_binding_combo_resolver_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  kbcr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output kbcr_pkg::rsp_t out_rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int N  = kbcr_pkg::NUM_KEYS;
  localparam int KW = kbcr_pkg::KEY_W;
  localparam int CW = kbcr_pkg::CNT_W;

  kbcr_pkg::state_e state_q, state_d;

  logic [31:0]   mem_q [N];
  logic [N-1:0]  valid_q;
  logic [31:0]   rd_data_q;
  logic          rd_vld_q;
  logic [KW-1:0] rd_addr;
  logic          mem_we;
  logic [KW-1:0] mem_waddr;

  logic [31:0]   usable_q, menu_mask_q;
  logic          sound_q;

  logic [N-1:0]  ckm_q, ckm_d;
  logic [31:0]   cam_q, cam_d;
  logic [15:0]   prev_q, prev_d;
  logic [6:0]    vol_q, vol_d;
  logic [3:0]    slot_q, slot_d;
  logic          out_valid_q, out_valid_d;
  kbcr_pkg::rsp_t out_rsp_q, out_rsp_d;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [N-1:0]  keys_q, keys_d;
  logic [31:0]   seen1_q, seen1_d;
  logic [31:0]   seen2_q, seen2_d;
  logic [15:0]   act_lo_q [2];
  logic [15:0]   act_lo_d [2];
  logic [15:0]   ev_q, ev_d;
  logic [15:0]   rising_q, rising_d;
  logic          menu_q, menu_d;
  logic [31:0]   acts_q, acts_d;
  logic [31:0]   shared_q, shared_d;
  logic          pl_q, pl_d;

  logic          accept;
  logic          in_range;
  logic [31:0]   rd_word;
  logic [KW-1:0] idx_a, ptr_a;
  logic          idx_end, ptr_end, idx_last;
  logic [31:0]   key_shared;
  logic          done_go;

  assign accept     = in_valid_i && (state_q == kbcr_pkg::ST_IDLE);
  assign in_range   = 32'(in_req_i.key_index) < N;
  assign mem_we     = accept && (in_req_i.command == kbcr_pkg::CMD_WRITE) && in_range;
  assign mem_waddr  = KW'(in_req_i.key_index);
  assign rd_word    = rd_vld_q ? rd_data_q : '0;
  assign idx_a      = idx_q[KW-1:0];
  assign ptr_a      = ptr_q[KW-1:0];
  assign idx_end    = idx_q == CW'(N);
  assign idx_last   = idx_q == CW'(N - 1);
  assign ptr_end    = ptr_q == CW'(N);
  assign rd_addr    = (state_q == kbcr_pkg::ST_S_SRCH) ? ptr_a : idx_a;
  assign key_shared = rd_word & cam_q;
  assign done_go    = (state_q == kbcr_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = state_q != kbcr_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_req_i.binding_word;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kbcr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i.command)
            kbcr_pkg::CMD_PREPARE: state_d = kbcr_pkg::ST_P1_RD;
            kbcr_pkg::CMD_SAMPLE:  state_d = kbcr_pkg::ST_S_SEL;
            default:               state_d = kbcr_pkg::ST_DONE;
          endcase
        end
      end
      kbcr_pkg::ST_P1_RD:  state_d = kbcr_pkg::ST_P1_ACC;
      kbcr_pkg::ST_P1_ACC: state_d = idx_last ? kbcr_pkg::ST_P2_RD : kbcr_pkg::ST_P1_RD;
      kbcr_pkg::ST_P2_RD:  state_d = kbcr_pkg::ST_P2_ACC;
      kbcr_pkg::ST_P2_ACC: state_d = idx_last ? kbcr_pkg::ST_DONE : kbcr_pkg::ST_P2_RD;
      kbcr_pkg::ST_S_SEL: begin
        if (idx_end) begin
          state_d = kbcr_pkg::ST_FIN;
        end else if (keys_q[idx_a]) begin
          state_d = kbcr_pkg::ST_S_KEY;
        end
      end
      kbcr_pkg::ST_S_KEY: begin
        if (rd_word != '0 && ckm_q[idx_a] && key_shared != '0) begin
          state_d = kbcr_pkg::ST_S_SRCH;
        end else begin
          state_d = kbcr_pkg::ST_S_SEL;
        end
      end
      kbcr_pkg::ST_S_SRCH: begin
        if (ptr_end) begin
          state_d = kbcr_pkg::ST_S_SEL;
        end else if (keys_q[ptr_a]) begin
          state_d = kbcr_pkg::ST_S_CHK;
        end
      end
      kbcr_pkg::ST_S_CHK: begin
        if ((rd_word & shared_q) != '0) begin
          state_d = kbcr_pkg::ST_S_SEL;
        end else begin
          state_d = kbcr_pkg::ST_S_SRCH;
        end
      end
      kbcr_pkg::ST_FIN: state_d = kbcr_pkg::ST_DONE;
      kbcr_pkg::ST_DONE: begin
        if (done_go) begin
          state_d = kbcr_pkg::ST_IDLE;
        end
      end
      default: state_d = kbcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    logic        add_en;
    logic        add_pl;
    logic [31:0] add_val;
    logic [15:0] rise;
    ckm_d       = ckm_q;
    cam_d       = cam_q;
    prev_d      = prev_q;
    vol_d       = vol_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    keys_d      = keys_q;
    seen1_d     = seen1_q;
    seen2_d     = seen2_q;
    act_lo_d    = act_lo_q;
    ev_d        = ev_q;
    rising_d    = rising_q;
    menu_d      = menu_q;
    acts_d      = acts_q;
    shared_d    = shared_q;
    pl_d        = pl_q;
    add_en      = 1'b0;
    add_pl      = 1'b0;
    add_val     = '0;
    rise        = ev_q & ~prev_q;

    unique case (state_q)
      kbcr_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d       = '0;
          seen1_d     = '0;
          seen2_d     = '0;
          act_lo_d[0] = '0;
          act_lo_d[1] = '0;
          ev_d        = '0;
          rising_d    = '0;
          menu_d      = 1'b0;
          keys_d      = in_req_i.pad_keys[N-1:0] & usable_q[N-1:0];
          if (in_req_i.command == kbcr_pkg::CMD_SAMPLE) begin
            menu_d = (in_req_i.pad_keys & menu_mask_q) != '0;
          end
        end
      end
      kbcr_pkg::ST_P1_ACC: begin
        seen2_d = seen2_q | (seen1_q & rd_word);
        seen1_d = seen1_q | rd_word;
        idx_d   = idx_q + CW'(1);
        if (idx_last) begin
          cam_d = (seen2_q | (seen1_q & rd_word)) & kbcr_pkg::COMBO_ELIGIBLE;
          ckm_d = '0;
          idx_d = '0;
        end
      end
      kbcr_pkg::ST_P2_ACC: begin
        ckm_d[idx_a] = key_shared != '0;
        idx_d        = idx_q + CW'(1);
      end
      kbcr_pkg::ST_S_SEL: begin
        if (!idx_end && !keys_q[idx_a]) begin
          idx_d = idx_q + CW'(1);
        end
      end
      kbcr_pkg::ST_S_KEY: begin
        acts_d   = rd_word;
        shared_d = key_shared;
        pl_d     = rd_word[kbcr_pkg::PLAYER_BIT];
        ptr_d    = idx_q + CW'(1);
        if (rd_word != '0 && ckm_q[idx_a] && key_shared != '0) begin
          idx_d = idx_q;
        end else begin
          idx_d   = idx_q + CW'(1);
          add_en  = rd_word != '0;
          add_pl  = rd_word[kbcr_pkg::PLAYER_BIT];
          add_val = ckm_q[idx_a] ? (rd_word & ~cam_q) : rd_word;
        end
      end
      kbcr_pkg::ST_S_SRCH: begin
        if (ptr_end) begin
          add_en  = 1'b1;
          add_pl  = pl_q;
          add_val = acts_q & ~cam_q;
          idx_d   = idx_q + CW'(1);
        end else if (!keys_q[ptr_a]) begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      kbcr_pkg::ST_S_CHK: begin
        if ((rd_word & shared_q) != '0) begin
          add_en        = 1'b1;
          add_pl        = pl_q;
          add_val       = shared_q;
          keys_d[idx_a] = 1'b0;
          keys_d[ptr_a] = 1'b0;
          idx_d         = idx_q + CW'(1);
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      kbcr_pkg::ST_FIN: begin
        if ((ev_q & kbcr_pkg::EV_VOLUME_ANY) != '0 && sound_q) begin
          if ((ev_q & kbcr_pkg::EV_VOLUME_UP) != '0) begin
            if (vol_q < kbcr_pkg::VOLUME_MAX) begin
              vol_d = vol_q + 7'd1;
            end
          end else if (vol_q != '0) begin
            vol_d = vol_q - 7'd1;
          end
        end
        rising_d = rise;
        if ((rise & kbcr_pkg::EV_SLOT_ANY) != '0) begin
          if ((rise & kbcr_pkg::EV_SLOT_DOWN) != '0) begin
            slot_d = (slot_q == '0 || slot_q > kbcr_pkg::SLOT_LAST) ?
                     kbcr_pkg::SLOT_LAST : slot_q - 4'd1;
          end else begin
            slot_d = (slot_q >= kbcr_pkg::SLOT_LAST) ? 4'd0 : slot_q + 4'd1;
          end
        end
        prev_d = ev_q;
      end
      kbcr_pkg::ST_DONE: begin
        if (done_go) begin
          out_valid_d              = 1'b1;
          out_rsp_d.pad_player_one = act_lo_q[0];
          out_rsp_d.pad_player_two = act_lo_q[1];
          out_rsp_d.new_events     = rising_q;
          out_rsp_d.menu_request   = menu_q;
          out_rsp_d.volume_level   = vol_q;
          out_rsp_d.save_slot      = slot_q;
        end
      end
      default: begin
      end
    endcase

    if (add_en) begin
      act_lo_d[add_pl] = act_lo_q[add_pl] | add_val[15:0];
      ev_d             = ev_q | add_val[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kbcr_pkg::ST_IDLE;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      usable_q    <= '1;
      menu_mask_q <= 32'd1;
      sound_q     <= 1'b1;
      ckm_q       <= '0;
      cam_q       <= '0;
      prev_q      <= '0;
      vol_q       <= kbcr_pkg::VOLUME_RESET;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= valid_q[rd_addr];
      ckm_q       <= ckm_d;
      cam_q       <= cam_d;
      prev_q      <= prev_d;
      vol_q       <= vol_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kbcr_pkg::CFG_USABLE_KEY_MASK: usable_q    <= cfg_data_i;
          kbcr_pkg::CFG_MENU_KEY_MASK:   menu_mask_q <= cfg_data_i;
          kbcr_pkg::CFG_SOUND_ENABLED:   sound_q     <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    idx_q     <= idx_d;
    ptr_q     <= ptr_d;
    keys_q    <= keys_d;
    seen1_q   <= seen1_d;
    seen2_q   <= seen2_d;
    act_lo_q  <= act_lo_d;
    ev_q      <= ev_d;
    rising_q  <= rising_d;
    menu_q    <= menu_d;
    acts_q    <= acts_d;
    shared_q  <= shared_d;
    pl_q      <= pl_d;
  end

  // volume and slot stay in range
  `KBCR_ASSERT(a_vol_range, clk_i, rst_ni, vol_q <= kbcr_pkg::VOLUME_MAX)
  `KBCR_ASSERT(a_slot_range, clk_i, rst_ni, slot_q <= kbcr_pkg::SLOT_LAST)
  // partner search only looks above the current key
  `KBCR_ASSERT(a_ptr_srch, clk_i, rst_ni, state_q == kbcr_pkg::ST_S_SRCH |-> ptr_q > idx_q)
  `KBCR_ASSERT(a_ptr_chk, clk_i, rst_ni, state_q == kbcr_pkg::ST_S_CHK |-> ptr_q > idx_q)
  // a finished request lands in the output register
  `KBCR_ASSERT(a_done_out, clk_i, rst_ni, done_go |=> out_valid_q)

endmodule
